// ===== src/aesp_pkg.sv =====
// ----------------------------------------------------------------------------
// aesp_pkg
// Shared types and constants for the escape sequence parser: byte classes,
// queue entry, result record and sizing constants.
// ----------------------------------------------------------------------------
package aesp_pkg;

  // Sequence limits
  localparam int MAX_PARAMS    = 16;
  localparam int TEXT_CAPACITY = 64;
  localparam int PCW           = $clog2(MAX_PARAMS + 1);
  localparam int TCW           = $clog2(TEXT_CAPACITY);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Special byte values
  localparam logic [7:0] C_ESC    = 8'h1B;
  localparam logic [7:0] C_BEL    = 8'h07;
  localparam logic [7:0] C_ST     = 8'h9C;
  localparam logic [7:0] C_HASH   = 8'h23;
  localparam logic [7:0] C_LPAREN = 8'h28;
  localparam logic [7:0] C_RPAREN = 8'h29;
  localparam logic [7:0] C_LBRACK = 8'h5B;
  localparam logic [7:0] C_RBRACK = 8'h5D;
  localparam logic [7:0] C_QUEST  = 8'h3F;
  localparam logic [7:0] C_SEMI   = 8'h3B;

  // Byte classes
  typedef enum logic [3:0] {
    CL_OTHER  = 4'd0,
    CL_ESC    = 4'd1,
    CL_LETTER = 4'd2,
    CL_DIGIT  = 4'd3,
    CL_BEL    = 4'd4,
    CL_ST     = 4'd5,
    CL_HASH   = 4'd6,
    CL_LPAREN = 4'd7,
    CL_RPAREN = 4'd8,
    CL_LBRACK = 4'd9,
    CL_RBRACK = 4'd10,
    CL_QUEST  = 4'd11,
    CL_SEMI   = 4'd12
  } cls_t;

  // Classified byte as queued
  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
  } item_t;

  // Queue status
  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCW-1:0] count;
  } q_stat_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PARAM = 2'd0,
    KIND_TEXT  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // One result record
  typedef struct packed {
    kind_t       kind;
    logic [5:0]  index;
    logic [15:0] value;
    logic        absent;
    logic [7:0]  seq_class;
    logic [7:0]  command;
    logic        private_flag;
    logic [4:0]  param_count;
    logic [5:0]  text_length;
    logic        overflow;
    logic        last;
  } res_t;

endpackage

// ===== src/aesp_front.sv =====
// ----------------------------------------------------------------------------
// aesp_front
// Input side: takes raw bytes, sorts each into a byte class and writes the
// classified byte into the queue.
// ----------------------------------------------------------------------------
module aesp_front
  import aesp_pkg::*;
(
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  q_stat_t    q_stat,
  output logic       wr_en,
  output item_t      wr_item
);

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c = CL_OTHER;
    if (b == C_ESC) c = CL_ESC;
    else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
             (b >= 8'h3C && b <= 8'h3E)) c = CL_LETTER;
    else if (b >= 8'h30 && b <= 8'h39) c = CL_DIGIT;
    else if (b == C_BEL)    c = CL_BEL;
    else if (b == C_ST)     c = CL_ST;
    else if (b == C_HASH)   c = CL_HASH;
    else if (b == C_LPAREN) c = CL_LPAREN;
    else if (b == C_RPAREN) c = CL_RPAREN;
    else if (b == C_LBRACK) c = CL_LBRACK;
    else if (b == C_RBRACK) c = CL_RBRACK;
    else if (b == C_QUEST)  c = CL_QUEST;
    else if (b == C_SEMI)   c = CL_SEMI;
    return c;
  endfunction

  // Transfer a pushed byte into the queue whenever it has room
  assign full          = q_stat.full;
  assign wr_en         = push && !q_stat.full;
  assign wr_item.data  = in_byte;
  assign wr_item.cls   = classify(in_byte);

endmodule

// ===== src/aesp_fifo.sv =====
// ----------------------------------------------------------------------------
// aesp_fifo
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module aesp_fifo
  import aesp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  item_t   wr_item,
  input  logic    rd_en,
  output item_t   rd_item,
  output q_stat_t stat
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + QAW'(1);
      if (rd_en) rd_ptr <= rd_ptr + QAW'(1);
      if (wr_en && !rd_en) count <= count + QCW'(1);
      else if (rd_en && !wr_en) count <= count - QCW'(1);
    end
  end

  assign rd_item    = mem[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == QCW'(QDEPTH));
  assign stat.empty = (count == '0);

endmodule

// ===== src/aesp_back.sv =====
// ----------------------------------------------------------------------------
// aesp_back
// Sequence engine: runs the phase table on queued bytes, keeps the sequence
// registers and loads results into the output register.
// ----------------------------------------------------------------------------
module aesp_back
  import aesp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   head,
  input  q_stat_t q_stat,
  output logic    rd_en,
  output logic    empty,
  input  logic    pop,
  output res_t    res
);

  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_ESC     = 5'b00010,
    PH_CSI     = 5'b00100,
    PH_OSC     = 5'b01000,
    PH_CHARSET = 5'b10000
  } phase_t;

  phase_t         phase, phase_next;
  logic [7:0]     class_reg, class_reg_next;
  logic           private_reg, private_reg_next;
  logic [15:0]    param_accum, param_accum_next;
  logic           have_digits, have_digits_next;
  logic [PCW-1:0] param_total, param_total_next;
  logic [TCW-1:0] text_total, text_total_next;
  logic           overflow_reg, overflow_reg_next;

  logic           out_valid;
  res_t           out_res;
  res_t           res_next;
  logic           emit;
  logic           deq;
  logic           fire;
  logic [19:0]    acc_prod;

  // Engine steps when a byte is queued and the output register can take it
  assign fire     = !q_stat.empty && (!out_valid || pop);
  assign acc_prod = 20'(param_accum) * 20'd10 + 20'(head.data[3:0]);

  always_comb begin
    phase_next        = phase;
    class_reg_next    = class_reg;
    private_reg_next  = private_reg;
    param_accum_next  = param_accum;
    have_digits_next  = have_digits;
    param_total_next  = param_total;
    text_total_next   = text_total;
    overflow_reg_next = overflow_reg;
    res_next          = '0;
    emit              = 1'b0;
    deq               = 1'b1;

    if (head.cls == CL_ESC) begin
      // Restart: drop anything in progress
      phase_next        = PH_ESC;
      class_reg_next    = '0;
      private_reg_next  = 1'b0;
      param_accum_next  = '0;
      have_digits_next  = 1'b0;
      param_total_next  = '0;
      text_total_next   = '0;
      overflow_reg_next = 1'b0;
    end else begin
      case (phase)
        PH_ESC: begin
          case (head.cls)
            CL_LETTER, CL_DIGIT: begin
              emit                  = 1'b1;
              res_next.kind         = KIND_DONE;
              res_next.seq_class    = class_reg;
              res_next.command      = head.data;
              res_next.private_flag = private_reg;
              res_next.param_count  = 5'(param_total);
              res_next.text_length  = 6'(text_total);
              res_next.overflow     = overflow_reg;
              res_next.last         = 1'b1;
              phase_next            = PH_START;
            end
            CL_HASH, CL_LPAREN, CL_RPAREN: begin
              class_reg_next = head.data;
              phase_next     = PH_CHARSET;
            end
            CL_LBRACK: begin
              class_reg_next = head.data;
              phase_next     = PH_CSI;
            end
            CL_RBRACK: begin
              class_reg_next = head.data;
              phase_next     = PH_OSC;
            end
            default: begin
              emit           = 1'b1;
              res_next.kind  = KIND_ERROR;
              res_next.value = 16'(head.data);
              res_next.last  = 1'b1;
              phase_next     = PH_START;
            end
          endcase
        end

        PH_CSI: begin
          case (head.cls)
            CL_LETTER: begin
              if (have_digits) begin
                // Store pending digits first, keep the byte for the done item
                deq              = 1'b0;
                param_accum_next = '0;
                have_digits_next = 1'b0;
                if (param_total < PCW'(MAX_PARAMS)) begin
                  emit             = 1'b1;
                  res_next.kind    = KIND_PARAM;
                  res_next.index   = 6'(param_total);
                  res_next.value   = param_accum;
                  param_total_next = param_total + PCW'(1);
                end else begin
                  overflow_reg_next = 1'b1;
                end
              end else begin
                emit                  = 1'b1;
                res_next.kind         = KIND_DONE;
                res_next.seq_class    = class_reg;
                res_next.command      = head.data;
                res_next.private_flag = private_reg;
                res_next.param_count  = 5'(param_total);
                res_next.text_length  = 6'(text_total);
                res_next.overflow     = overflow_reg;
                res_next.last         = 1'b1;
                phase_next            = PH_START;
              end
            end
            CL_DIGIT: begin
              have_digits_next = 1'b1;
              if (acc_prod > 20'd65535) begin
                param_accum_next  = 16'hFFFF;
                overflow_reg_next = 1'b1;
              end else begin
                param_accum_next = acc_prod[15:0];
              end
            end
            CL_QUEST: begin
              private_reg_next = 1'b1;
            end
            CL_SEMI: begin
              param_accum_next = '0;
              have_digits_next = 1'b0;
              if (param_total < PCW'(MAX_PARAMS)) begin
                emit             = 1'b1;
                res_next.kind    = KIND_PARAM;
                res_next.index   = 6'(param_total);
                res_next.value   = have_digits ? param_accum : 16'd0;
                res_next.absent  = !have_digits;
                res_next.last    = 1'b1;
                param_total_next = param_total + PCW'(1);
              end else begin
                overflow_reg_next = 1'b1;
              end
            end
            default: begin
              emit           = 1'b1;
              res_next.kind  = KIND_ERROR;
              res_next.value = 16'(head.data);
              res_next.last  = 1'b1;
              phase_next     = PH_START;
            end
          endcase
        end

        PH_OSC: begin
          if (head.cls == CL_BEL || head.cls == CL_ST) begin
            emit                  = 1'b1;
            res_next.kind         = KIND_DONE;
            res_next.seq_class    = class_reg;
            res_next.private_flag = private_reg;
            res_next.param_count  = 5'(param_total);
            res_next.text_length  = 6'(text_total);
            res_next.overflow     = overflow_reg;
            res_next.last         = 1'b1;
            phase_next            = PH_START;
          end else if (text_total < TCW'(TEXT_CAPACITY - 1)) begin
            emit            = 1'b1;
            res_next.kind   = KIND_TEXT;
            res_next.index  = 6'(text_total);
            res_next.value  = 16'(head.data);
            res_next.last   = 1'b1;
            text_total_next = text_total + TCW'(1);
          end else begin
            overflow_reg_next = 1'b1;
          end
        end

        PH_CHARSET: begin
          if (head.cls == CL_LETTER || head.cls == CL_DIGIT) begin
            emit                  = 1'b1;
            res_next.kind         = KIND_DONE;
            res_next.seq_class    = class_reg;
            res_next.command      = head.data;
            res_next.private_flag = private_reg;
            res_next.param_count  = 5'(param_total);
            res_next.text_length  = 6'(text_total);
            res_next.overflow     = overflow_reg;
            res_next.last         = 1'b1;
          end else begin
            emit           = 1'b1;
            res_next.kind  = KIND_ERROR;
            res_next.value = 16'(head.data);
            res_next.last  = 1'b1;
          end
          phase_next = PH_START;
        end

        default: begin
          // Start phase: anything but ESC is illegal
          emit           = 1'b1;
          res_next.kind  = KIND_ERROR;
          res_next.value = 16'(head.data);
          res_next.last  = 1'b1;
          phase_next     = PH_START;
        end
      endcase
    end
  end

  // Sequence registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      class_reg    <= '0;
      private_reg  <= 1'b0;
      param_accum  <= '0;
      have_digits  <= 1'b0;
      param_total  <= '0;
      text_total   <= '0;
      overflow_reg <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      class_reg    <= class_reg_next;
      private_reg  <= private_reg_next;
      param_accum  <= param_accum_next;
      have_digits  <= have_digits_next;
      param_total  <= param_total_next;
      text_total   <= text_total_next;
      overflow_reg <= overflow_reg_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_res <= res_next;
    end
  end

  assign rd_en = fire && deq;
  assign empty = !out_valid;
  assign res   = out_res;

endmodule

// ===== src/ansi_escape_sequence_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser
// Byte-serial escape sequence parser with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// Bytes go through the queue and the sequence engine into the output register.
// Throughput: 1 byte per cycle while results are popped; a CSI final byte with
// pending digits stalls the engine (parameter result, then done result).
// The front queue holds 4 bytes so the input keeps flowing across that stall.
// Reset: synchronous rst empties queue and output, returns to start phase.
module ansi_escape_sequence_parser
  import aesp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [5:0]  index,
  output logic [15:0] value,
  output logic        absent,
  output logic [7:0]  seq_class,
  output logic [7:0]  command,
  output logic        private_flag,
  output logic [4:0]  param_count,
  output logic [5:0]  text_length,
  output logic        overflow,
  output logic        last
);

  q_stat_t q_stat;
  logic    q_wr_en;
  logic    q_rd_en;
  item_t   q_wr_item;
  item_t   q_head;
  res_t    res;

  aesp_front u_front (
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .q_stat  (q_stat),
    .wr_en   (q_wr_en),
    .wr_item (q_wr_item)
  );

  aesp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr_en),
    .wr_item (q_wr_item),
    .rd_en   (q_rd_en),
    .rd_item (q_head),
    .stat    (q_stat)
  );

  aesp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .q_stat (q_stat),
    .rd_en  (q_rd_en),
    .empty  (empty),
    .pop    (pop),
    .res    (res)
  );

  // Result fields
  assign kind         = res.kind;
  assign index        = res.index;
  assign value        = res.value;
  assign absent       = res.absent;
  assign seq_class    = res.seq_class;
  assign command      = res.command;
  assign private_flag = res.private_flag;
  assign param_count  = res.param_count;
  assign text_length  = res.text_length;
  assign overflow     = res.overflow;
  assign last         = res.last;

  // Only a parameter result can be followed by another from the same byte
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_PARAM) |-> last)
    else $error("non-parameter result without last");

  // Error results carry no sequence context
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_ERROR) |->
      (index == 6'd0 && seq_class == 8'd0 && command == 8'd0 &&
       param_count == 5'd0 && !overflow && !absent))
    else $error("error result carries sequence fields");

  // Queue occupancy grows by one on a write without a read
  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    (q_wr_en && !q_rd_en) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count did not advance on write");

endmodule
